>>> src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ucer_pkg.sv
package ucer_pkg;

  localparam int Ep0MaxPacket = 64;
  localparam int DescRomDepth = 64;
  localparam int RomInitLen = 59;
  localparam int CfgOffset = 18;

  localparam logic [2:0] KIND_SETUP = 3'd0;
  localparam logic [2:0] KIND_IN = 3'd1;
  localparam logic [2:0] KIND_OUT = 3'd2;
  localparam logic [2:0] KIND_BUS_RESET = 3'd3;

  localparam logic [1:0] HS_ACK = 2'd0;
  localparam logic [1:0] HS_NAK = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  localparam logic [7:0] REQ_GET_STATUS = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE = 8'd10;

  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_CONFIG = 8'd2;

  localparam logic [7:0] EPA_IN2 = 8'h82;
  localparam logic [7:0] EPA_OUT2 = 8'h02;
  localparam logic [7:0] EPA_IN1 = 8'h81;
  localparam logic [7:0] EPA_OUT1 = 8'h01;

  // byte-source selects for the packet stream
  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_ROM = 2'd1;
  localparam logic [1:0] MODE_CFG = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] endpoint;
    logic       toggle_ok;
    logic [7:0] request_type;
    logic [7:0] request;
    logic [15:0] value;
    logic [15:0] windex;
    logic [15:0] wlength;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
    logic [6:0] ep0_tx_len;
    logic [1:0] ep0_tx_handshake;
    logic [1:0] ep0_rx_handshake;
    logic [1:0] ep0_toggles;
    logic [1:0] ep1_toggles;
    logic [1:0] ep2_toggles;
    logic [6:0] device_address;
    logic [7:0] config_value;
  } out_item_t;

  function automatic logic [7:0] rom_byte(input int unsigned i);
    logic [7:0] b;
    b = 8'h00;
    unique case (i)
      0: b = 8'h12;  1: b = 8'h01;  2: b = 8'h10;  3: b = 8'h01;
      4: b = 8'h00;  5: b = 8'h00;  6: b = 8'h00;  7: b = 8'h40;
      8: b = 8'h23;  9: b = 8'h01; 10: b = 8'h67; 11: b = 8'h45;
      12: b = 8'h00; 13: b = 8'h01; 14: b = 8'h00; 15: b = 8'h00;
      16: b = 8'h00; 17: b = 8'h01;
      18: b = 8'h09; 19: b = 8'h02; 20: b = 8'h29; 21: b = 8'h00;
      22: b = 8'h02; 23: b = 8'h01; 24: b = 8'h00; 25: b = 8'hE0;
      26: b = 8'h32;
      27: b = 8'h09; 28: b = 8'h04; 29: b = 8'h00; 30: b = 8'h00;
      31: b = 8'h01; 32: b = 8'h03; 33: b = 8'h01; 34: b = 8'h01;
      35: b = 8'h00;
      36: b = 8'h07; 37: b = 8'h05; 38: b = 8'h81; 39: b = 8'h03;
      40: b = 8'h08; 41: b = 8'h00; 42: b = 8'h01;
      43: b = 8'h09; 44: b = 8'h04; 45: b = 8'h01; 46: b = 8'h00;
      47: b = 8'h01; 48: b = 8'h03; 49: b = 8'h01; 50: b = 8'h02;
      51: b = 8'h00;
      52: b = 8'h07; 53: b = 8'h05; 54: b = 8'h82; 55: b = 8'h03;
      56: b = 8'h04; 57: b = 8'h00; 58: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> src/ucer_stream_if.sv
interface ucer_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/usb_control_endpoint_responder.sv
// USB endpoint 0 standard-request responder. One event per input transfer;
// a setup or endpoint 0 IN that arms a packet of n bytes produces n result
// transfers (one byte each, last on the final one), any other event one
// result with has_data low. The event is decoded first, then each packet
// byte is read through the descriptor ROM's registered read port and then
// loaded into the output register; output backpressure can stall a byte.
// One item is in work at a time.
`include "assert_macros.svh"

module usb_control_endpoint_responder #(
  parameter int EP0_MAX_PACKET = ucer_pkg::Ep0MaxPacket,
  parameter int DESCRIPTOR_ROM_DEPTH = ucer_pkg::DescRomDepth
) (
  input logic clk,
  input logic rst_n,
  ucer_stream_if.sink   in_ch,
  ucer_stream_if.source out_ch
);
  localparam int AW = $clog2(DESCRIPTOR_ROM_DEPTH);
  localparam logic [15:0] MaxPkt = 16'(EP0_MAX_PACKET);
  localparam logic [15:0] RomDepth = 16'(DESCRIPTOR_ROM_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DESCRIPTOR_ROM_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEND = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [7:0]    sreq_r, sreq_nxt;
  logic [6:0]    addr_r, addr_nxt;
  logic [7:0]    cfg_r, cfg_nxt;
  logic [1:0]    tog_r [3];
  logic [1:0]    tog_nxt [3];
  logic [1:0]    hstx_r [3];
  logic [1:0]    hstx_nxt [3];
  logic [1:0]    hsrx_r [3];
  logic [1:0]    hsrx_nxt [3];
  logic [6:0]    txlen_r, txlen_nxt;

  // byte streaming
  logic [6:0]    cnt_r, cnt_nxt;
  logic [6:0]    n_r, n_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [7:0]    rom_q;

  logic          ov_r, ov_nxt;
  ucer_pkg::out_item_t ob_r, ob_nxt;

  ucer_desc_rom #(.Depth(DESCRIPTOR_ROM_DEPTH)) u_rom (
    .clk(clk), .rd_addr(rd_addr_r), .rd_data(rom_q)
  );

  ucer_pkg::in_item_t it;
  assign it = in_ch.payload;
  assign in_ch.ready = (state_r == ST_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.payload = ob_r;

  function automatic logic [15:0] chunk(input logic [15:0] r);
    return (r >= MaxPkt) ? MaxPkt : r;
  endfunction

  // pointer plus one packet stays below twice the depth plus a packet
  function automatic logic [AW-1:0] wrap(input logic [15:0] v);
    logic [15:0] t;
    t = v;
    if (t >= RomDepth) t = t - RomDepth;
    if (t >= RomDepth) t = t - RomDepth;
    return t[AW-1:0];
  endfunction

  always_comb begin
    logic        err;
    logic [15:0] dlen;
    logic [15:0] len;
    logic [15:0] r;
    logic [3:0]  ep;
    ucer_pkg::out_item_t o;
    state_nxt = state_r;
    ptr_nxt = ptr_r; rem_nxt = rem_r; sreq_nxt = sreq_r;
    addr_nxt = addr_r; cfg_nxt = cfg_r; txlen_nxt = txlen_r;
    tog_nxt = tog_r; hstx_nxt = hstx_r; hsrx_nxt = hsrx_r;
    cnt_nxt = cnt_r; n_nxt = n_r; mode_nxt = mode_r;
    rd_addr_nxt = rd_addr_r; rd_pend_nxt = 1'b0;
    ov_nxt = ov_r; ob_nxt = ob_r;
    err = 1'b0; dlen = '0; len = '0; r = '0; ep = it.endpoint;
    o = '0;

    if (out_ch.valid && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          len = '0;
          mode_nxt = ucer_pkg::MODE_ZERO;
          priority case (it.kind)
            ucer_pkg::KIND_SETUP: begin
              tog_nxt[0] = 2'b11;
              hsrx_nxt[0] = ucer_pkg::HS_ACK;
              hstx_nxt[0] = ucer_pkg::HS_NAK;
              r = it.wlength;
              sreq_nxt = it.request;
              if (it.request_type[6:5] != 2'b00) begin
                err = 1'b1;
              end else begin
                priority case (it.request)
                  ucer_pkg::REQ_GET_DESCRIPTOR: begin
                    priority if (it.value[15:8] == ucer_pkg::DT_DEVICE) begin
                      ptr_nxt = '0;
                      dlen = {8'd0, ucer_pkg::rom_byte(0)};
                    end else if (it.value[15:8] == ucer_pkg::DT_CONFIG) begin
                      ptr_nxt = wrap(16'(ucer_pkg::CfgOffset));
                      dlen = {8'd0, ucer_pkg::rom_byte(
                        (ucer_pkg::CfgOffset + 2) % DESCRIPTOR_ROM_DEPTH)};
                    end else begin
                      err = 1'b1;
                    end
                    if (r > dlen) r = dlen;
                    rd_addr_nxt = ptr_nxt;
                    mode_nxt = ucer_pkg::MODE_ROM;
                    ptr_nxt = wrap(16'(ptr_nxt) + chunk(r));
                  end
                  ucer_pkg::REQ_SET_ADDRESS: r = {8'd0, it.value[7:0]};
                  ucer_pkg::REQ_GET_CONFIG: begin
                    mode_nxt = ucer_pkg::MODE_CFG;
                    if (r > 16'd1) r = 16'd1;
                  end
                  ucer_pkg::REQ_SET_CONFIG: cfg_nxt = it.value[7:0];
                  ucer_pkg::REQ_CLEAR_FEATURE: begin
                    if (it.request_type[4:0] == 5'd2) begin
                      priority case (it.windex[7:0])
                        ucer_pkg::EPA_IN2: begin
                          tog_nxt[2] = tog_r[2] & 2'b10;
                          hstx_nxt[2] = ucer_pkg::HS_NAK;
                        end
                        ucer_pkg::EPA_OUT2: begin
                          tog_nxt[2] = tog_r[2] & 2'b01;
                          hsrx_nxt[2] = ucer_pkg::HS_ACK;
                        end
                        ucer_pkg::EPA_IN1: begin
                          tog_nxt[1] = tog_r[1] & 2'b10;
                          hstx_nxt[1] = ucer_pkg::HS_NAK;
                        end
                        ucer_pkg::EPA_OUT1: begin
                          tog_nxt[1] = tog_r[1] & 2'b01;
                          hsrx_nxt[1] = ucer_pkg::HS_ACK;
                        end
                        default: err = 1'b1;
                      endcase
                    end else begin
                      err = 1'b1;
                    end
                  end
                  ucer_pkg::REQ_GET_INTERFACE: if (r > 16'd1) r = 16'd1;
                  ucer_pkg::REQ_GET_STATUS: if (r > 16'd2) r = 16'd2;
                  default: err = 1'b1;
                endcase
              end
              if (err) begin
                hsrx_nxt[0] = ucer_pkg::HS_STALL;
                hstx_nxt[0] = ucer_pkg::HS_STALL;
                mode_nxt = ucer_pkg::MODE_ZERO;
              end else begin
                if (it.request_type[7]) begin
                  len = chunk(r);
                  r = r - len;
                end
                txlen_nxt = len[6:0];
                hstx_nxt[0] = ucer_pkg::HS_ACK;
              end
              rem_nxt = r;
            end
            ucer_pkg::KIND_IN: begin
              if (ep == 4'd0) begin
                if (sreq_r == ucer_pkg::REQ_GET_DESCRIPTOR) begin
                  len = chunk(rem_r);
                  rd_addr_nxt = ptr_r;
                  mode_nxt = ucer_pkg::MODE_ROM;
                  rem_nxt = rem_r - len;
                  ptr_nxt = wrap(16'(ptr_r) + len);
                  txlen_nxt = len[6:0];
                  tog_nxt[0] = tog_r[0] ^ 2'b01;
                end else begin
                  if (sreq_r == ucer_pkg::REQ_SET_ADDRESS) addr_nxt = rem_r[6:0];
                  else txlen_nxt = '0;
                  hsrx_nxt[0] = ucer_pkg::HS_ACK;
                  hstx_nxt[0] = ucer_pkg::HS_NAK;
                  tog_nxt[0] = 2'b00;
                end
              end else if (ep == 4'd1 || ep == 4'd2) begin
                tog_nxt[ep[1:0]] = tog_r[ep[1:0]] ^ 2'b01;
                hstx_nxt[ep[1:0]] = ucer_pkg::HS_NAK;
              end
            end
            ucer_pkg::KIND_OUT: begin
              if ((ep == 4'd1 || ep == 4'd2) && it.toggle_ok)
                tog_nxt[ep[1:0]] = tog_r[ep[1:0]] ^ 2'b10;
            end
            ucer_pkg::KIND_BUS_RESET: begin
              addr_nxt = '0;
              for (int i = 0; i < 3; i++) begin
                tog_nxt[i] = 2'b00;
                hsrx_nxt[i] = ucer_pkg::HS_ACK;
                hstx_nxt[i] = ucer_pkg::HS_NAK;
              end
            end
            default: ;
          endcase
          n_nxt = len[6:0];
          cnt_nxt = '0;
          if (len == '0) begin
            state_nxt = ST_WAIT;
          end else begin
            state_nxt = ST_SEND;
            rd_pend_nxt = 1'b1;
            rd_addr_nxt = rd_addr_nxt;
          end
        end
      end
      ST_SEND: begin
        // rom_q holds the byte at the address read last cycle
        if (!ov_nxt && !rd_pend_r) begin
          o.data_byte = (mode_r == ucer_pkg::MODE_ROM) ? rom_q :
                        (mode_r == ucer_pkg::MODE_CFG && cnt_r == '0) ? cfg_r : 8'd0;
          o.has_data = 1'b1;
          o.last = (cnt_r == n_r - 7'd1);
          o.ep0_tx_len = txlen_r;
          o.ep0_tx_handshake = hstx_r[0];
          o.ep0_rx_handshake = hsrx_r[0];
          o.ep0_toggles = tog_r[0];
          o.ep1_toggles = tog_r[1];
          o.ep2_toggles = tog_r[2];
          o.device_address = addr_r;
          o.config_value = cfg_r;
          ob_nxt = o;
          ov_nxt = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
          if (o.last) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_addr_nxt = (rd_addr_r == LastAddr) ? '0 : rd_addr_r + AW'(1);
            rd_pend_nxt = 1'b1;
          end
        end else if (rd_pend_r) begin
          rd_pend_nxt = 1'b0;
        end
      end
      ST_WAIT: begin
        if (!ov_nxt) begin
          o.last = 1'b1;
          o.ep0_tx_len = txlen_r;
          o.ep0_tx_handshake = hstx_r[0];
          o.ep0_rx_handshake = hsrx_r[0];
          o.ep0_toggles = tog_r[0];
          o.ep1_toggles = tog_r[1];
          o.ep2_toggles = tog_r[2];
          o.device_address = addr_r;
          o.config_value = cfg_r;
          ob_nxt = o;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r <= '0; rem_r <= '0; sreq_r <= '0;
      addr_r <= '0; cfg_r <= '0; txlen_r <= '0;
      for (int i = 0; i < 3; i++) begin
        tog_r[i] <= 2'b00;
        hstx_r[i] <= ucer_pkg::HS_NAK;
        hsrx_r[i] <= ucer_pkg::HS_ACK;
      end
      ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
      cnt_r <= '0; n_r <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt; rem_r <= rem_nxt; sreq_r <= sreq_nxt;
      addr_r <= addr_nxt; cfg_r <= cfg_nxt; txlen_r <= txlen_nxt;
      tog_r <= tog_nxt; hstx_r <= hstx_nxt; hsrx_r <= hsrx_nxt;
      ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
      cnt_r <= cnt_nxt; n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    rd_addr_r <= rd_addr_nxt;
    ob_r <= ob_nxt;
  end

  `ASSERT_ALWAYS(a_onehot_state, $onehot(state_r), "state not one-hot")
  `ASSERT_ALWAYS(a_no_accept_busy, !(in_ch.ready && state_r != ST_IDLE), "ready while busy")
  `ASSERT_ALWAYS(a_len_bound, txlen_r <= 7'(EP0_MAX_PACKET), "armed length too big")
  `ASSERT_NEXT(a_wait_one, state_r == ST_WAIT && !ov_r, ov_r && ob_r.last && !ob_r.has_data,
    "idle result missing")
endmodule

>>> src/ucer_desc_rom.sv
// Descriptor ROM as a synchronous memory with a registered read port
module ucer_desc_rom #(
  parameter int Depth = ucer_pkg::DescRomDepth
) (
  input  logic                     clk,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [7:0]               rd_data
);
  logic [7:0] mem [Depth];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      mem[i] = ucer_pkg::rom_byte(i);
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule
